@@ rtl/core/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants of the byte ring buffer
// Request codes, sequencer states, and the interface structs between the
// sequencer and its shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  // datapath widths that do not follow the depth parameter
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 13;
  // wide enough for a pointer at the largest supported depth plus a borrow bit
  localparam int unsigned ALU_W  = 22;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // request codes carried by req_type
  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_WADV  = 3'd3,
    REQ_RADV  = 3'd4,
    REQ_CLEAR = 3'd5
  } req_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LEVEL,
    S_FREE,
    S_SAT,
    S_CLIP,
    S_MOVE,
    S_RUN,
    S_FILL,
    S_ADDR,
    S_EMIT
  } state_e;

  // operations of the shared arithmetic unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/brb_alu.sv @@
// ----------------------------------------------------------------------------
// brb_alu: shared add / subtract / compare unit
// One adder shared by the steps of the sequencer: pointer moves, fill level,
// free space, clipping compares and byte addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_alu (
  input  brb_pkg::alu_req_t req_i,
  output brb_pkg::alu_rsp_t rsp_o
);

  logic [brb_pkg::ALU_W:0] diff;

  // subtract with borrow out, the borrow doubles as unsigned a < b
  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_comb begin
    rsp_o.lt = diff[brb_pkg::ALU_W];
    unique case (req_i.op)
      brb_pkg::ALU_ADD: rsp_o.sum = req_i.a + req_i.b;
      brb_pkg::ALU_SUB: rsp_o.sum = diff[brb_pkg::ALU_W-1:0];
      default:          rsp_o.sum = req_i.a + req_i.b;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/brb_mem.sv @@
// ----------------------------------------------------------------------------
// brb_mem: byte store of the ring buffer
// Single write port and single read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_mem #(
  parameter int unsigned ADDR_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [ADDR_BITS-1:0]        waddr_i,
  input  wire logic [brb_pkg::BYTE_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [ADDR_BITS-1:0]        raddr_i,
  output logic      [brb_pkg::BYTE_W-1:0]  rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [brb_pkg::BYTE_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/byte_ring_buffer_core.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_core: circular byte FIFO with wrap-bit pointers
// Sequencer around one shared adder and a byte store. Handles write bytes,
// read and peek bursts, pointer advances and clear.
// ----------------------------------------------------------------------------
// Results: a write byte gives one only with run_end; a read or peek gives one
// per byte returned (one with no byte); advance, clear and other codes give one.
// One transaction at a time: the next is accepted only while busy is low.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset clears both pointers and the run byte count; no clearing pass.
`default_nettype none

module byte_ring_buffer_core #(
  parameter int unsigned ADDR_BITS = 12,
  parameter int unsigned MAX_BURST = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   req_type_i,
  input  wire logic [brb_pkg::BYTE_W-1:0]   write_byte_i,
  input  wire logic                         run_end_i,
  input  wire logic [brb_pkg::CNT_W-1:0]    request_count_i,
  output logic                              strobe_o,
  output logic      [brb_pkg::BYTE_W-1:0]   read_byte_o,
  output logic                              last_of_run_o,
  output logic      [brb_pkg::CNT_W-1:0]    moved_count_o,
  output logic      [brb_pkg::CNT_W-1:0]    fill_level_o,
  output logic                              is_empty_o
);

  localparam int unsigned PTR_W = ADDR_BITS + 1;
  localparam int unsigned KW    = $clog2(MAX_BURST + 1);
  localparam int unsigned AW    = brb_pkg::ALU_W;
  localparam int unsigned CW    = brb_pkg::CNT_W;

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(1) << ADDR_BITS;
  localparam logic [AW-1:0]    DEPTH_A = AW'(DEPTH_P);
  localparam logic [AW-1:0]    BURST_A = AW'(MAX_BURST);
  localparam logic [AW-1:0]    ONE_A   = AW'(1);

  brb_pkg::state_e state_q, state_d;
  brb_pkg::req_e   type_q, type_d;

  logic [brb_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       end_q, end_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [PTR_W-1:0]           lim_q, lim_d;
  logic [PTR_W-1:0]           wp_q, wp_d;
  logic [PTR_W-1:0]           rp_q, rp_d;
  logic [PTR_W-1:0]           start_q, start_d;
  logic [PTR_W-1:0]           lvl_q, lvl_d;
  logic [CW-1:0]              run_q, run_d;
  logic [KW-1:0]              k_q, k_d;
  logic                       burst_q, burst_d;

  brb_pkg::alu_req_t alu_req;
  brb_pkg::alu_rsp_t alu_rsp;

  logic                       mem_we;
  logic                       mem_re;
  logic [brb_pkg::BYTE_W-1:0] mem_rdata;

  logic          room;
  logic [CW-1:0] run_next;
  logic          last_hit;
  logic [AW-1:0] lvl_ext;

  brb_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  brb_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q[ADDR_BITS-1:0]),
    .wdata_i (byte_q),
    .re_i    (mem_re),
    .raddr_i (alu_rsp.sum[ADDR_BITS-1:0]),
    .rdata_o (mem_rdata)
  );

  // a write byte is stored only while the buffer is not full
  assign room = (lim_q != DEPTH_P);

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brb_pkg::S_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      run_q   <= run_d;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    byte_q  <= byte_d;
    end_q   <= end_d;
    cnt_q   <= cnt_d;
    lim_q   <= lim_d;
    start_q <= start_d;
    lvl_q   <= lvl_d;
    k_q     <= k_d;
    burst_q <= burst_d;
  end

  // sequencer: next state, shared adder operands and register updates
  always_comb begin
    state_d  = state_q;
    type_d   = type_q;
    byte_d   = byte_q;
    end_d    = end_q;
    cnt_d    = cnt_q;
    lim_d    = lim_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    start_d  = start_q;
    lvl_d    = lvl_q;
    run_d    = run_q;
    k_d      = k_q;
    burst_d  = burst_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    run_next = run_q;
    alu_req  = '{op: brb_pkg::ALU_ADD, a: '0, b: '0};

    unique case (state_q)
      brb_pkg::S_IDLE: begin
        if (start) begin
          type_d = brb_pkg::req_e'(req_type_i);
          byte_d = write_byte_i;
          end_d  = run_end_i;
          case (req_type_i) inside
            brb_pkg::REQ_READ, brb_pkg::REQ_PEEK,
            brb_pkg::REQ_WADV, brb_pkg::REQ_RADV: cnt_d = request_count_i;
            default:                              cnt_d = '0;
          endcase
          state_d = brb_pkg::S_LEVEL;
        end
      end

      // current fill level
      brb_pkg::S_LEVEL: begin
        alu_req = '{op: brb_pkg::ALU_SUB, a: AW'(wp_q), b: AW'(rp_q)};
        lim_d   = alu_rsp.sum[PTR_W-1:0];
        unique case (type_q) inside
          brb_pkg::REQ_READ, brb_pkg::REQ_PEEK:  state_d = brb_pkg::S_SAT;
          brb_pkg::REQ_WADV:                     state_d = brb_pkg::S_FREE;
          brb_pkg::REQ_RADV:                     state_d = brb_pkg::S_CLIP;
          brb_pkg::REQ_WRITE, brb_pkg::REQ_CLEAR: state_d = brb_pkg::S_MOVE;
          default:                               state_d = brb_pkg::S_FILL;
        endcase
      end

      // free space for a write advance
      brb_pkg::S_FREE: begin
        alu_req = '{op: brb_pkg::ALU_SUB, a: DEPTH_A, b: AW'(lim_q)};
        lim_d   = alu_rsp.sum[PTR_W-1:0];
        state_d = brb_pkg::S_CLIP;
      end

      // saturate the burst length
      brb_pkg::S_SAT: begin
        alu_req = '{op: brb_pkg::ALU_SUB, a: AW'(cnt_q), b: BURST_A};
        cnt_d   = alu_rsp.lt ? cnt_q : CW'(MAX_BURST);
        state_d = brb_pkg::S_CLIP;
      end

      // clip to the fill level or free space
      brb_pkg::S_CLIP: begin
        alu_req = '{op: brb_pkg::ALU_SUB, a: AW'(cnt_q), b: AW'(lim_q)};
        cnt_d   = alu_rsp.lt ? cnt_q : CW'(lim_q);
        state_d = brb_pkg::S_MOVE;
      end

      // pointer update and byte store write
      brb_pkg::S_MOVE: begin
        start_d = rp_q;
        state_d = brb_pkg::S_FILL;
        case (type_q)
          brb_pkg::REQ_WRITE: begin
            state_d = brb_pkg::S_RUN;
            if (room) begin
              mem_we  = 1'b1;
              alu_req = '{op: brb_pkg::ALU_ADD, a: AW'(wp_q), b: ONE_A};
              wp_d    = alu_rsp.sum[PTR_W-1:0];
            end
          end
          brb_pkg::REQ_READ, brb_pkg::REQ_RADV: begin
            alu_req = '{op: brb_pkg::ALU_ADD, a: AW'(rp_q), b: AW'(cnt_q)};
            rp_d    = alu_rsp.sum[PTR_W-1:0];
          end
          brb_pkg::REQ_WADV: begin
            alu_req = '{op: brb_pkg::ALU_ADD, a: AW'(wp_q), b: AW'(cnt_q)};
            wp_d    = alu_rsp.sum[PTR_W-1:0];
          end
          brb_pkg::REQ_CLEAR: begin
            wp_d = '0;
            rp_d = '0;
          end
          default: begin
          end
        endcase
      end

      // saturating count of bytes taken in this write run
      brb_pkg::S_RUN: begin
        alu_req = '{op: brb_pkg::ALU_ADD, a: AW'(run_q), b: ONE_A};
        if (room && run_q != brb_pkg::CNT_MAX) begin
          run_next = alu_rsp.sum[CW-1:0];
        end
        cnt_d   = run_next;
        run_d   = end_q ? '0 : run_next;
        state_d = end_q ? brb_pkg::S_FILL : brb_pkg::S_IDLE;
      end

      // fill level after the step
      brb_pkg::S_FILL: begin
        alu_req = '{op: brb_pkg::ALU_SUB, a: AW'(wp_q), b: AW'(rp_q)};
        lvl_d   = alu_rsp.sum[PTR_W-1:0];
        k_d     = '0;
        burst_d = (type_q == brb_pkg::REQ_READ || type_q == brb_pkg::REQ_PEEK) &&
                  (cnt_q != '0);
        state_d = burst_d ? brb_pkg::S_ADDR : brb_pkg::S_EMIT;
      end

      // byte address of the next burst byte
      brb_pkg::S_ADDR: begin
        alu_req = '{op: brb_pkg::ALU_ADD, a: AW'(start_q), b: AW'(k_q)};
        mem_re  = 1'b1;
        state_d = brb_pkg::S_EMIT;
      end

      // result cycle, step the burst index
      brb_pkg::S_EMIT: begin
        alu_req = '{op: brb_pkg::ALU_ADD, a: AW'(k_q), b: ONE_A};
        k_d     = alu_rsp.sum[KW-1:0];
        state_d = (burst_q && !last_hit) ? brb_pkg::S_ADDR : brb_pkg::S_IDLE;
      end

      default: state_d = brb_pkg::S_IDLE;
    endcase
  end

  // result ports
  assign last_hit      = (alu_rsp.sum[CW-1:0] == cnt_q);
  assign lvl_ext       = AW'(lvl_q);
  assign busy          = (state_q != brb_pkg::S_IDLE);
  assign strobe_o      = (state_q == brb_pkg::S_EMIT);
  assign last_of_run_o = !burst_q || last_hit;
  assign read_byte_o   = burst_q ? mem_rdata : '0;
  assign moved_count_o = last_of_run_o ? cnt_q : '0;
  assign fill_level_o  = lvl_ext[CW-1:0];
  assign is_empty_o    = (lvl_q == '0);

`ifndef NO_ASSERTIONS
  // results only come out of a transaction in progress
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy)
    else $error("result strobe while idle");

  // an accepted transaction occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");

  // occupancy never exceeds the buffer depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PTR_W'(wp_q - rp_q) <= DEPTH_P)
    else $error("fill level above depth");

  // burst index stays below the burst length
  a_burst_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && burst_q) |-> (CW'(k_q) < cnt_q))
    else $error("burst index out of range");
`endif

endmodule

`default_nettype wire

@@ tb/tb_byte_ring_buffer_core.sv @@
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_core: self-checking bench for the byte ring buffer
// Drives write bytes, read and peek bursts, pointer advances, clear and the
// spare request codes through the start/busy handshake. A shadow copy of the
// buffer predicts every strobed result, and each result is checked field by
// field against the oldest prediction still due.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_byte_ring_buffer_core;

  localparam int unsigned BYTE_W       = brb_pkg::BYTE_W;
  localparam int unsigned CNT_W        = brb_pkg::CNT_W;
  localparam int unsigned ADDR_BITS    = 12;
  localparam int unsigned MAX_BURST    = 64;
  localparam int unsigned DEPTH        = 1 << ADDR_BITS;
  localparam int unsigned PTR_W        = ADDR_BITS + 1;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 40;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  // request codes the block treats as no-ops
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              last;
    logic [CNT_W-1:0]  moved;
    logic [CNT_W-1:0]  fill;
    logic              empty;
  } ring_result_t;

  // shadow copy of the buffer and the queue of results it predicts
  class ring_shadow;
    logic [BYTE_W-1:0] store [DEPTH];
    bit                written [DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [CNT_W-1:0]  run_cnt;
    ring_result_t      due_results [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       peak_fill;
    int unsigned       capped_bursts;

    function new();
      wr_ptr        = '0;
      rd_ptr        = '0;
      run_cnt       = '0;
      mismatches    = 0;
      checked       = 0;
      peak_fill     = 0;
      capped_bursts = 0;
    endfunction

    function logic [PTR_W-1:0] fill();
      return wr_ptr - rd_ptr;
    endfunction

    // every result reports the level after the whole request
    function void push_result(logic [BYTE_W-1:0] b, logic last, logic [CNT_W-1:0] moved);
      ring_result_t r;
      logic [PTR_W-1:0] lvl;
      lvl         = fill();
      r.read_byte = b;
      r.last      = last;
      r.moved     = moved;
      r.fill      = CNT_W'(lvl);
      r.empty     = (lvl == '0);
      due_results.push_back(r);
      if (lvl > peak_fill) peak_fill = lvl;
    endfunction

    // count for a read or peek that never touches a never-written byte
    function logic [CNT_W-1:0] safe_count(logic [CNT_W-1:0] want);
      logic [PTR_W-1:0] pos;
      int unsigned span;
      int unsigned n;
      span = (want > MAX_BURST) ? MAX_BURST : want;
      if (span > fill()) span = fill();
      n   = 0;
      pos = rd_ptr;
      while (n < span && written[pos[ADDR_BITS-1:0]]) begin
        n++;
        pos = pos + 1'b1;
      end
      return (n == span) ? want : CNT_W'(n);
    endfunction

    // note an accepted transaction and predict its results
    function void apply_request(logic [2:0] op, logic [BYTE_W-1:0] data, logic run_end,
                                logic [CNT_W-1:0] count);
      logic [PTR_W-1:0] lvl;
      logic [PTR_W-1:0] n;
      logic [PTR_W-1:0] first;
      logic [PTR_W-1:0] pos;
      logic [PTR_W-1:0] moved;
      lvl = fill();
      case (op)
        brb_pkg::REQ_WRITE: begin
          if (lvl < DEPTH) begin
            store[wr_ptr[ADDR_BITS-1:0]]   = data;
            written[wr_ptr[ADDR_BITS-1:0]] = 1'b1;
            wr_ptr = wr_ptr + 1'b1;
            if (run_cnt != brb_pkg::CNT_MAX) run_cnt = run_cnt + 1'b1;
          end
          if (run_end) begin
            push_result('0, 1'b1, run_cnt);
            run_cnt = '0;
          end
        end
        brb_pkg::REQ_READ, brb_pkg::REQ_PEEK: begin
          n = (count > MAX_BURST) ? PTR_W'(MAX_BURST) : PTR_W'(count);
          if (count > MAX_BURST && lvl > MAX_BURST) capped_bursts++;
          if (n > lvl) n = lvl;
          first = rd_ptr;
          if (op == brb_pkg::REQ_READ) rd_ptr = rd_ptr + n;
          if (n == '0) push_result('0, 1'b1, '0);
          for (int k = 0; k < n; k++) begin
            pos = first + PTR_W'(k);
            push_result(store[pos[ADDR_BITS-1:0]], k == n - 1,
                        (k == n - 1) ? CNT_W'(n) : '0);
          end
        end
        brb_pkg::REQ_WADV: begin
          moved = PTR_W'(DEPTH - lvl);
          if (count < moved) moved = PTR_W'(count);
          wr_ptr = wr_ptr + moved;
          push_result('0, 1'b1, CNT_W'(moved));
        end
        brb_pkg::REQ_RADV: begin
          moved = lvl;
          if (count < moved) moved = PTR_W'(count);
          rd_ptr = rd_ptr + moved;
          push_result('0, 1'b1, CNT_W'(moved));
        end
        brb_pkg::REQ_CLEAR: begin
          wr_ptr = '0;
          rd_ptr = '0;
          push_result('0, 1'b1, '0);
        end
        default: begin
          push_result('0, 1'b1, '0);
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
    endfunction

    // compare one strobed result against the oldest prediction
    function void compare_output(ring_result_t got);
      ring_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing due, expected none, actual byte %0d moved %0d",
                   $time, got.read_byte, got.moved);
        return;
      end
      want = due_results.pop_front();
      checked++;
      check_field("read_byte", want.read_byte, got.read_byte);
      check_field("last_of_run", want.last, got.last);
      check_field("moved_count", want.moved, got.moved);
      check_field("fill_level", want.fill, got.fill);
      check_field("is_empty", want.empty, got.empty);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [2:0]        req_type_i;
  logic [BYTE_W-1:0] write_byte_i;
  logic              run_end_i;
  logic [CNT_W-1:0]  request_count_i;
  logic              strobe_o;
  logic [BYTE_W-1:0] read_byte_o;
  logic              last_of_run_o;
  logic [CNT_W-1:0]  moved_count_o;
  logic [CNT_W-1:0]  fill_level_o;
  logic              is_empty_o;

  ring_shadow  shadow;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycles;

  byte_ring_buffer_core #(
    .ADDR_BITS(ADDR_BITS),
    .MAX_BURST(MAX_BURST)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .write_byte_i   (write_byte_i),
    .run_end_i      (run_end_i),
    .request_count_i(request_count_i),
    .strobe_o       (strobe_o),
    .read_byte_o    (read_byte_o),
    .last_of_run_o  (last_of_run_o),
    .moved_count_o  (moved_count_o),
    .fill_level_o   (fill_level_o),
    .is_empty_o     (is_empty_o)
  );

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               shadow.due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    ring_result_t got;
    if (strobe_o) begin
      got.read_byte = read_byte_o;
      got.last      = last_of_run_o;
      got.moved     = moved_count_o;
      got.fill      = fill_level_o;
      got.empty     = is_empty_o;
      shadow.compare_output(got);
    end
  end

  task automatic hold_off(int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // one transaction; start stays high so back-to-back requests need no gap
  task automatic send_request(logic [2:0] op, logic [BYTE_W-1:0] data, logic run_end,
                              logic [CNT_W-1:0] count);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      hold_off($urandom_range(0, 6));
    end
    burst_left--;
    start           <= 1'b1;
    req_type_i      <= op;
    write_byte_i    <= data;
    run_end_i       <= run_end;
    request_count_i <= count;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    shadow.apply_request(op, data, run_end, count);
    items_sent++;
  endtask

  // write run with random bytes, marked on its final byte
  task automatic send_run(int unsigned len);
    for (int i = 0; i < len; i++)
      send_request(brb_pkg::REQ_WRITE, BYTE_W'($urandom_range(0, 255)), i == len - 1,
                   CNT_W'($urandom_range(0, 4096)));
  endtask

  function automatic logic [CNT_W-1:0] random_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FULL_COUNT;
      2, 3:    return CNT_W'($urandom_range(65, 4095));
      default: return CNT_W'($urandom_range(1, 64));
    endcase
  endfunction

  // mostly well-formed write runs and short reads so the level can climb
  task automatic random_traffic();
    int unsigned      target;
    int unsigned      pick;
    logic [CNT_W-1:0] count;
    logic [2:0]       op;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      pick  = $urandom_range(0, 99);
      count = ($urandom_range(0, 4) == 0) ? random_count() : CNT_W'($urandom_range(1, 8));
      if (pick < 45) begin
        send_run($urandom_range(1, 24));
      end else if (pick < 50) begin
        send_request(brb_pkg::REQ_WRITE, BYTE_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), random_count());
      end else begin
        if (pick < 67)      op = brb_pkg::REQ_READ;
        else if (pick < 76) op = brb_pkg::REQ_PEEK;
        else if (pick < 80) op = brb_pkg::REQ_WADV;
        else if (pick < 90) op = brb_pkg::REQ_RADV;
        else if (pick < 94) op = brb_pkg::REQ_CLEAR;
        else if (pick < 97) op = REQ_SPARE_6;
        else                op = REQ_SPARE_7;
        if (op == brb_pkg::REQ_READ || op == brb_pkg::REQ_PEEK)
          count = shadow.safe_count(count);
        send_request(op, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), count);
      end
    end
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = brb_pkg::REQ_WRITE;
    write_byte_i    = '0;
    run_end_i       = 1'b0;
    request_count_i = '0;
    items_sent      = 0;
    burst_left      = 0;
    cycles          = 0;
    shadow          = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing to read on an empty buffer
    send_request(brb_pkg::REQ_READ, 8'h5a, 1'b1, 13'd5);
    send_request(brb_pkg::REQ_PEEK, 8'h00, 1'b0, '0);
    // byte extremes in a two-byte run
    send_request(brb_pkg::REQ_WRITE, 8'h00, 1'b0, FULL_COUNT);
    send_request(brb_pkg::REQ_WRITE, 8'hff, 1'b1, FULL_COUNT);
    // peek clipped to the fill level, then a one-byte and a zero-byte read
    send_request(brb_pkg::REQ_PEEK, 8'h00, 1'b0, FULL_COUNT);
    send_request(brb_pkg::REQ_READ, 8'h00, 1'b0, 13'd1);
    send_request(brb_pkg::REQ_READ, 8'h00, 1'b0, '0);
    send_request(brb_pkg::REQ_RADV, 8'h00, 1'b0, FULL_COUNT);
    // park both pointers just short of the address wrap
    send_request(brb_pkg::REQ_WADV, 8'h00, 1'b0, 13'd4090);
    send_request(brb_pkg::REQ_RADV, 8'h00, 1'b0, 13'd4090);
    send_run(6);
    send_request(brb_pkg::REQ_READ, 8'h00, 1'b0, 13'd64);
    // full buffer: dropped byte and a write advance with no room
    send_request(brb_pkg::REQ_WADV, 8'h00, 1'b0, FULL_COUNT);
    send_request(brb_pkg::REQ_WRITE, 8'ha5, 1'b1, '0);
    send_request(brb_pkg::REQ_WADV, 8'h00, 1'b0, 13'd5);
    send_request(brb_pkg::REQ_RADV, 8'h00, 1'b0, FULL_COUNT);
    // run byte count survives a clear
    send_request(brb_pkg::REQ_WRITE, 8'h3c, 1'b0, '0);
    send_request(brb_pkg::REQ_CLEAR, 8'h00, 1'b1, FULL_COUNT);
    send_request(brb_pkg::REQ_WRITE, 8'hc3, 1'b1, '0);
    send_request(REQ_SPARE_6, 8'hff, 1'b1, FULL_COUNT);
    send_request(REQ_SPARE_7, 8'h00, 1'b0, '0);

    random_traffic();

    start <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked, %0d mismatches",
             items_sent, shadow.checked, shadow.mismatches);
    $display("peak fill level %0d, %0d bursts capped at %0d bytes",
             shadow.peak_fill, shadow.capped_bursts, MAX_BURST);
    if (shadow.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
